### rtl/ttg_pkg.sv
// Shared widths, constants and types of the triangle tangent generator.
package ttg_pkg;

    localparam int FIELD_W         = 16;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_AXES        = 3;
    localparam int DELTA_W         = FIELD_W + 1;
    localparam int PROD_W          = 2 * DELTA_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int TAN_W           = 32;
    localparam int FRAC_SHIFT      = 20;
    localparam int QUEUE_DEPTH     = 2;
    localparam int COPIES          = 3;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [TAN_W-1:0]          tan_t;

    localparam tan_t TAN_MAX = {1'b0, {(TAN_W-1){1'b1}}};
    localparam tan_t TAN_MIN = {1'b1, {(TAN_W-1){1'b0}}};

    // One complete triangle, reduced to the deltas against its first vertex.
    typedef struct packed {
        delta_t [NUM_AXES-1:0] dp1;
        delta_t [NUM_AXES-1:0] dp2;
        delta_t                d1u;
        delta_t                d1v;
        delta_t                d2u;
        delta_t                d2v;
    } tri_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        tri_t data;
    } tri_req_t;

endpackage

### rtl/ttg_front.sv
// Front end: collects vertices and forms the deltas of each finished triangle.
module ttg_front #(
    parameter int COORD_WIDTH = ttg_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vertex_valid,
    output logic                         vertex_ready,
    input  logic [ttg_pkg::FIELD_W-1:0]  pos_x,
    input  logic [ttg_pkg::FIELD_W-1:0]  pos_y,
    input  logic [ttg_pkg::FIELD_W-1:0]  pos_z,
    input  logic [ttg_pkg::FIELD_W-1:0]  tex_u,
    input  logic [ttg_pkg::FIELD_W-1:0]  tex_v,
    output logic                         push_valid,
    input  logic                         push_ready,
    output ttg_pkg::tri_t                push_data
);
    import ttg_pkg::*;

    localparam int EXT_W = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    function automatic delta_t sext(input logic [FIELD_W-1:0] f);
        sext = {{(DELTA_W-EXT_W){f[EXT_W-1]}}, f[EXT_W-1:0]};
    endfunction

    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    delta_t [NUM_AXES-1:0] first_pos_reg;
    delta_t [NUM_AXES-1:0] second_pos_reg;
    delta_t                first_u_reg;
    delta_t                first_v_reg;
    delta_t                second_u_reg;
    delta_t                second_v_reg;
    delta_t [NUM_AXES-1:0] vpos;
    delta_t                vu;
    delta_t                vv;
    logic                  accept;

    assign vpos = {sext(pos_z), sext(pos_y), sext(pos_x)};
    assign vu   = sext(tex_u);
    assign vv   = sext(tex_v);

    assign vertex_ready = (phase_reg != PH_THIRD) || push_ready;
    assign push_valid   = vertex_valid && (phase_reg == PH_THIRD);
    assign accept       = vertex_valid && vertex_ready;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_THIRD;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_FIRST))
        begin
            first_pos_reg <= vpos;
            first_u_reg   <= vu;
            first_v_reg   <= vv;
        end
        if (accept && (phase_reg == PH_SECOND))
        begin
            second_pos_reg <= vpos;
            second_u_reg   <= vu;
            second_v_reg   <= vv;
        end
    end

    // Deltas fit in DELTA_W since each operand spans at most EXT_W bits.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            push_data.dp1[i] = second_pos_reg[i] - first_pos_reg[i];
            push_data.dp2[i] = vpos[i] - first_pos_reg[i];
        end
        push_data.d1u = second_u_reg - first_u_reg;
        push_data.d1v = second_v_reg - first_v_reg;
        push_data.d2u = vu - first_u_reg;
        push_data.d2v = vv - first_v_reg;
    end

endmodule

### rtl/ttg_fifo.sv
// Short queue of triangle requests between the front and back ends.
module ttg_fifo #(
    parameter int DEPTH = ttg_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ttg_pkg::tri_t     push_data,
    output ttg_pkg::tri_req_t head,
    input  logic              pop
);
    import ttg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tri_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/ttg_div.sv
// Radix-4 restoring divider for one tangent component, with saturation.
module ttg_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ttg_pkg::SUM_W-1:0] dividend,
    input  logic [ttg_pkg::SUM_W-1:0] divisor,
    input  logic                     neg,
    output logic                     busy,
    output ttg_pkg::tan_t            result
);
    import ttg_pkg::*;

    localparam int ITER      = TAN_W / 2;
    localparam int CNT_W     = $clog2(ITER + 1);
    localparam int OVF_SHIFT = TAN_W - FRAC_SHIFT;
    localparam int REM_W     = SUM_W + 1;

    logic [REM_W-1:0] rem_reg;
    logic [TAN_W-1:0] low_reg;
    logic [TAN_W-1:0] quo_reg;
    logic [SUM_W-1:0] div_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] dvs;
    logic [REM_W-1:0] r1;
    logic [REM_W-1:0] r1s;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] r2s;
    logic             ge1;
    logic             ge2;

    assign busy = busy_reg;
    assign dvs  = {1'b0, div_reg};

    // Two quotient bits per cycle.
    always_comb
    begin
        r1  = {rem_reg[REM_W-2:0], low_reg[TAN_W-1]};
        ge1 = (r1 >= dvs);
        r1s = ge1 ? r1 - dvs : r1;
        r2  = {r1s[REM_W-2:0], low_reg[TAN_W-2]};
        ge2 = (r2 >= dvs);
        r2s = ge2 ? r2 - dvs : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The quotient reaches 2^32 exactly when dividend >= divisor * 2^12; those
    // cases saturate, so the remaining quotient always fits in TAN_W bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(dividend >> OVF_SHIFT);
            low_reg <= {dividend[OVF_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
            quo_reg <= '0;
            div_reg <= divisor;
            neg_reg <= neg;
            ovf_reg <= ({{OVF_SHIFT{1'b0}}, dividend} >= {divisor, {OVF_SHIFT{1'b0}}});
        end
        else if (busy_reg)
        begin
            rem_reg <= r2s;
            low_reg <= {low_reg[TAN_W-3:0], 2'b00};
            quo_reg <= {quo_reg[TAN_W-3:0], ge1, ge2};
        end
    end

    always_comb
    begin
        priority if (ovf_reg)
        begin
            result = neg_reg ? TAN_MIN : TAN_MAX;
        end
        else if (!neg_reg)
        begin
            result = quo_reg[TAN_W-1] ? TAN_MAX : quo_reg;
        end
        else
        begin
            result = (quo_reg > TAN_MIN) ? TAN_MIN : (~quo_reg + 1'b1);
        end
    end

endmodule

### rtl/ttg_back.sv
// Back end: products, determinant, division and the three result copies.
module ttg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ttg_pkg::tri_req_t           head,
    output logic                        pop,
    output logic                        tangent_valid,
    input  logic                        tangent_ready,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_x,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_y,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_z,
    output logic                        degenerate,
    output logic                        last_of_triangle
);
    import ttg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUB   = 3'd1;
    localparam logic [2:0] ST_ABS   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [1:0] COPY_LAST = 2'(COPIES - 1);

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [1:0]              copy_reg;
    logic signed [PROD_W-1:0] pa_reg [NUM_AXES];
    logic signed [PROD_W-1:0] pb_reg [NUM_AXES];
    logic signed [PROD_W-1:0] pc_reg;
    logic signed [PROD_W-1:0] pd_reg;
    logic signed [SUM_W-1:0]  num_reg [NUM_AXES];
    logic signed [SUM_W-1:0]  det_reg;
    logic [SUM_W-1:0]        nmag_reg [NUM_AXES];
    logic [SUM_W-1:0]        dmag_reg;
    logic [NUM_AXES-1:0]     neg_reg;
    logic                    degen_reg;
    tan_t                    tan_reg [NUM_AXES];
    tan_t                    quot [NUM_AXES];
    logic [NUM_AXES-1:0]     div_busy;
    logic                    div_start;

    assign pop              = (state_reg == ST_IDLE) && head.valid;
    assign div_start        = (state_reg == ST_START);
    assign tangent_valid    = (state_reg == ST_OUT);
    assign tangent_x        = tan_reg[0];
    assign tangent_y        = tan_reg[1];
    assign tangent_z        = tan_reg[2];
    assign degenerate       = degen_reg;
    assign last_of_triangle = (copy_reg == COPY_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (head.valid) state_next = ST_SUB;
            ST_SUB:   state_next = ST_ABS;
            ST_ABS:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_busy == '0) state_next = ST_OUT;
            ST_OUT:
            begin
                if (tangent_ready && (copy_reg == COPY_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            copy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV)
            begin
                copy_reg <= '0;
            end
            else if ((state_reg == ST_OUT) && tangent_ready)
            begin
                copy_reg <= copy_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pa_reg[i] <= PROD_W'($signed(head.data.dp1[i]))
                             * PROD_W'($signed(head.data.d2v));
                pb_reg[i] <= PROD_W'($signed(head.data.dp2[i]))
                             * PROD_W'($signed(head.data.d1v));
            end
            pc_reg <= PROD_W'($signed(head.data.d1u)) * PROD_W'($signed(head.data.d2v));
            pd_reg <= PROD_W'($signed(head.data.d1v)) * PROD_W'($signed(head.data.d2u));
        end
        if (state_reg == ST_SUB)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                num_reg[i] <= SUM_W'(pa_reg[i]) - SUM_W'(pb_reg[i]);
            end
            det_reg <= SUM_W'(pc_reg) - SUM_W'(pd_reg);
        end
        if (state_reg == ST_ABS)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                nmag_reg[i] <= num_reg[i][SUM_W-1] ? -num_reg[i] : num_reg[i];
                neg_reg[i]  <= num_reg[i][SUM_W-1] ^ det_reg[SUM_W-1];
            end
            dmag_reg  <= det_reg[SUM_W-1] ? -det_reg : det_reg;
            degen_reg <= (det_reg == '0);
        end
        if ((state_reg == ST_DIV) && (div_busy == '0))
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                tan_reg[i] <= degen_reg ? '0 : quot[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_div
        ttg_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (nmag_reg[g]),
            .divisor  (dmag_reg),
            .neg      (neg_reg[g]),
            .busy     (div_busy[g]),
            .result   (quot[g])
        );
    end

endmodule

### rtl/triangle_tangent_generator.sv
// Top level: per-triangle tangent generator from vertex positions and UVs.
// A triangle's third vertex request leads to its first tangent request via
// the queue, the products, the SUB, ABS and START states and radix-4 dividers.
// The back end starts a triangle only after all three copies of the last are
// taken; vertices are taken one per cycle while the queue has room for them.
// Reset (rst_n, asynchronous, active low) clears the vertex phase, the queue
// and the back-end sequencer; stored vertices are simply overwritten later.
module triangle_tangent_generator #(
    parameter int COORD_WIDTH = ttg_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vertex_valid,
    output logic                        vertex_ready,
    input  logic [ttg_pkg::FIELD_W-1:0] pos_x,
    input  logic [ttg_pkg::FIELD_W-1:0] pos_y,
    input  logic [ttg_pkg::FIELD_W-1:0] pos_z,
    input  logic [ttg_pkg::FIELD_W-1:0] tex_u,
    input  logic [ttg_pkg::FIELD_W-1:0] tex_v,
    output logic                        tangent_valid,
    input  logic                        tangent_ready,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_x,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_y,
    output logic [ttg_pkg::TAN_W-1:0]   tangent_z,
    output logic                        degenerate,
    output logic                        last_of_triangle
);
    import ttg_pkg::*;

    // The front end turns every third vertex request into a triangle record
    // of deltas against the first vertex and pushes it into a short queue.
    // The back end pops one record at a time, forms the products, numerators
    // and determinant, runs three dividers side by side and then repeats the
    // saturated tangent once for each vertex of the triangle.

    logic     push_valid;
    logic     push_ready;
    tri_t     push_data;
    tri_req_t head;
    logic     pop;

    ttg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    ttg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head       (head),
        .pop        (pop)
    );

    ttg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .tangent_valid    (tangent_valid),
        .tangent_ready    (tangent_ready),
        .tangent_x        (tangent_x),
        .tangent_y        (tangent_y),
        .tangent_z        (tangent_z),
        .degenerate       (degenerate),
        .last_of_triangle (last_of_triangle)
    );

endmodule
